### rtl/diff_drive_odometry_macros.svh
// Assertion helpers shared by the odometry RTL.
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define DDO_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define DDO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Constants and tables shared by the odometry block.
// ----------------------------------------------------------------------------
`default_nettype none
package ddo_pkg;
  localparam int CordicSteps = 24;
  localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;
  localparam logic signed [33:0] CordicOneQ30 = 34'sd652032874;
  localparam logic [31:0] SpacingReset = 32'd65536;
  localparam logic [31:0] SequenceReset = 32'd3;
  localparam logic [0:0] ReqWheel = 1'b0;
  localparam logic [0:0] ReqTick = 1'b1;

  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd536870912;  5'd1: r = 30'd316933406;
      5'd2: r = 30'd167458907;  5'd3: r = 30'd85004756;
      5'd4: r = 30'd42667331;   5'd5: r = 30'd21354465;
      5'd6: r = 30'd10679838;   5'd7: r = 30'd5340245;
      5'd8: r = 30'd2670163;    5'd9: r = 30'd1335087;
      5'd10: r = 30'd667544;    5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;    5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;     5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;     5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;       5'd21: r = 30'd326;
      5'd22: r = 30'd163;       5'd23: r = 30'd81;
      5'd24: r = 30'd41;        5'd25: r = 30'd20;
      5'd26: r = 30'd10;        5'd27: r = 30'd5;
      5'd28: r = 30'd3;         5'd29: r = 30'd1;
      5'd30: r = 30'd1;         default: r = 30'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Dead-reckoning odometry for a two-wheel robot with one shared sequencer.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_ready. A wheel request (req_type 0)
// updates the stored forward speed and turn rate and gives no result. A tick
// request (req_type 1) advances heading, rates and position and gives one
// result on out_valid/out_ready. The spacing register is written over
// cfg_valid/cfg_ready while the block is idle.
// A wheel request runs two 32-step square roots and a 56-step restoring
// divide, each with a setup and a finish state. The divide is skipped
// when the wheel speeds are equal or the spacing is zero. A tick request
// runs the CORDIC loop, which reuses one adder pair, and then waits for
// the result to be taken.
// The block takes one request at a time; in_ready is low until it is done.
// Reset clears pose, heading, forward speed and turn rate, sets the
// sequence number to three and the spacing to 1.0 m. A stalled receiver
// holds the result in the output register and the block accepts nothing
// until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module diff_drive_odometry (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [0:0]         req_type,
  input  wire logic signed [31:0] left_vel_x,
  input  wire logic signed [31:0] left_vel_y,
  input  wire logic signed [31:0] right_vel_x,
  input  wire logic signed [31:0] right_vel_y,
  input  wire logic [23:0]        elapsed_time,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      pos_x_out,
  output logic signed [47:0]      pos_y_out,
  output logic [31:0]             heading_out,
  output logic signed [31:0]      rate_x_out,
  output logic signed [31:0]      rate_y_out,
  output logic [31:0]             sequence_out
);
`include "diff_drive_odometry_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_SETUP, S_SQ_RUN, S_SQ_DONE, S_DIV_SETUP, S_DIV_RUN, S_DIV_DONE,
    S_ANG_MUL0, S_ANG_MUL1, S_ANG_MUL2, S_ANG_ADD, S_COR_SETUP, S_COR_RUN,
    S_QUAD, S_RATE_X, S_RATE_Y, S_POS_X, S_POS_Y, S_OUT
  } state_t;

  state_t state;
  logic [31:0] wheel_spacing;
  logic [31:0] forward_speed;
  logic signed [39:0] turn_rate;
  logic signed [47:0] pos_x, pos_y;
  logic [31:0] heading;
  logic [31:0] tick_sequence;
  logic [23:0] dt;
  logic signed [31:0] vel [4];
  logic wheel_sel;
  logic [63:0] sq_rem;
  logic [63:0] sq_src;
  logic [31:0] sq_root;
  logic [5:0] cnt;
  logic [31:0] speed_l;
  logic [55:0] div_num;
  logic [56:0] div_rem;
  logic [55:0] div_quo;
  logic div_neg;
  logic [63:0] prod;
  logic [31:0] dang;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic [1:0] quad;
  logic signed [33:0] trig_c, trig_s;
  logic signed [31:0] rate_x, rate_y;

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic [31:0] mag_a, mag_b;
  logic [63:0] mag_sum;
  always_comb begin
    mag_a = wheel_sel ? (vel[2][31] ? 32'(-vel[2]) : 32'(vel[2]))
                      : (vel[0][31] ? 32'(-vel[0]) : 32'(vel[0]));
    mag_b = wheel_sel ? (vel[3][31] ? 32'(-vel[3]) : 32'(vel[3]))
                      : (vel[1][31] ? 32'(-vel[1]) : 32'(vel[1]));
    mag_sum = 64'(mag_a) * 64'(mag_a) + 64'(mag_b) * 64'(mag_b);
  end

  // Bit-pair square root step: two radicand bits per cycle.
  logic [65:0] sq_trial;
  logic [65:0] sq_rem_sh;
  assign sq_rem_sh = {sq_rem, sq_src[63:62]};
  assign sq_trial = sq_rem_sh - {32'd0, sq_root, 2'b01};

  logic [56:0] div_trial;
  assign div_trial = {div_rem[55:0], div_num[55]} - {25'd0, wheel_spacing};

  logic [31:0] speed_r;
  logic [32:0] dm;
  assign speed_r = sq_root;
  assign dm = (speed_r >= speed_l) ? 33'(speed_r - speed_l) : 33'(speed_l - speed_r);

  logic [4:0] cstep;
  assign cstep = cnt[4:0];
  logic signed [33:0] cx_sh, cy_sh;
  assign cx_sh = cx >>> cstep;
  assign cy_sh = cy >>> cstep;

  logic [31:0] ang_next;
  assign ang_next = heading + (turn_rate[39] ? 32'(-dang) : dang);

  logic [33:0] trig_mag;
  logic trig_neg;
  logic [65:0] rate_prod;
  logic [33:0] rate_m;
  logic signed [31:0] rate_sat;
  always_comb begin
    trig_neg = (state == S_RATE_X) ? trig_c[33] : trig_s[33];
    trig_mag = (state == S_RATE_X) ? (trig_c[33] ? 34'(-trig_c) : 34'(trig_c))
                                   : (trig_s[33] ? 34'(-trig_s) : 34'(trig_s));
    rate_prod = 66'(forward_speed) * 66'(trig_mag);
    rate_m = rate_prod[63:30];
    if (trig_neg) rate_sat = (rate_m > 34'h80000000) ? 32'sh80000000 : 32'(-rate_m);
    else rate_sat = (rate_m > 34'h7fffffff) ? 32'sh7fffffff : 32'(rate_m);
  end

  logic signed [31:0] prate;
  logic signed [47:0] ppos;
  logic [31:0] prate_mag;
  logic [55:0] pprod;
  logic signed [49:0] psum;
  logic signed [47:0] pnew;
  always_comb begin
    prate = (state == S_POS_X) ? rate_x : rate_y;
    ppos = (state == S_POS_X) ? pos_x : pos_y;
    prate_mag = prate[31] ? 32'(-prate) : 32'(prate);
    pprod = 56'(prate_mag) * 56'(dt);
    psum = prate[31] ? 50'(ppos) - 50'(pprod[55:16]) : 50'(ppos) + 50'(pprod[55:16]);
    if (psum > 50'sh7fffffffffff) pnew = 48'sh7fffffffffff;
    else if (psum < -50'sh800000000000) pnew = -48'sh800000000000;
    else pnew = psum[47:0];
  end

  logic [39:0] tr_mag;
  assign tr_mag = turn_rate[39] ? 40'(-turn_rate) : 40'(turn_rate);
  always_comb begin
    mul_a = 32'd0;
    mul_b = ddo_pkg::InvTwoPiQ32;
    case (state)
      S_ANG_MUL1: mul_a = prod[63:32];
      S_ANG_MUL2: mul_a = prod[31:0];
      default: mul_a = 32'd0;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wheel_spacing <= ddo_pkg::SpacingReset;
      forward_speed <= '0;
      turn_rate <= '0;
      pos_x <= '0;
      pos_y <= '0;
      heading <= '0;
      tick_sequence <= ddo_pkg::SequenceReset;
      out_valid <= 1'b0;
      cnt <= '0;
      wheel_sel <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) wheel_spacing <= cfg_data;
          if (in_valid) begin
            vel[0] <= left_vel_x;
            vel[1] <= left_vel_y;
            vel[2] <= right_vel_x;
            vel[3] <= right_vel_y;
            dt <= elapsed_time;
            wheel_sel <= 1'b0;
            state <= (req_type == ddo_pkg::ReqTick) ? S_ANG_MUL0 : S_SQ_SETUP;
          end
        end
        S_SQ_SETUP: begin
          sq_src <= mag_sum;
          sq_rem <= '0;
          sq_root <= '0;
          cnt <= '0;
          state <= S_SQ_RUN;
        end
        S_SQ_RUN: begin
          sq_src <= {sq_src[61:0], 2'b00};
          if (!sq_trial[65]) begin
            sq_rem <= sq_trial[63:0];
            sq_root <= {sq_root[30:0], 1'b1};
          end else begin
            sq_rem <= sq_rem_sh[63:0];
            sq_root <= {sq_root[30:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) state <= S_SQ_DONE;
        end
        S_SQ_DONE: begin
          if (!wheel_sel) begin
            speed_l <= sq_root;
            wheel_sel <= 1'b1;
            state <= S_SQ_SETUP;
          end else begin
            state <= S_DIV_SETUP;
          end
        end
        S_DIV_SETUP: begin
          forward_speed <= 32'((33'(speed_l) + 33'(speed_r)) >> 1);
          div_neg <= (speed_r < speed_l);
          div_num <= {7'd0, dm[32:0], 16'd0};
          div_rem <= '0;
          div_quo <= '0;
          cnt <= '0;
          if (dm == 33'd0) begin
            turn_rate <= '0;
            state <= S_IDLE;
          end else if (wheel_spacing == 32'd0) begin
            turn_rate <= (speed_r < speed_l) ? 40'sh8000000000 : 40'sh7fffffffff;
            state <= S_IDLE;
          end else begin
            state <= S_DIV_RUN;
          end
        end
        S_DIV_RUN: begin
          div_num <= {div_num[54:0], 1'b0};
          if (!div_trial[56]) begin
            div_rem <= div_trial;
            div_quo <= {div_quo[54:0], 1'b1};
          end else begin
            div_rem <= {div_rem[55:0], div_num[55]};
            div_quo <= {div_quo[54:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd55) state <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          if (div_neg)
            turn_rate <= (div_quo > 56'h7fffffffff) ? 40'sh8000000000 : 40'(-div_quo);
          else
            turn_rate <= (div_quo > 56'h7fffffffff) ? 40'sh7fffffffff : 40'(div_quo);
          state <= S_IDLE;
        end
        S_ANG_MUL0: begin
          prod <= 64'(tr_mag) * 64'(dt);
          state <= S_ANG_MUL1;
        end
        S_ANG_MUL1: begin
          dang <= mul_p[31:0];
          state <= S_ANG_MUL2;
        end
        S_ANG_MUL2: begin
          dang <= dang + mul_p[63:32];
          state <= S_ANG_ADD;
        end
        S_ANG_ADD: begin
          heading <= ang_next;
          state <= S_COR_SETUP;
        end
        S_COR_SETUP: begin
          quad <= 2'(heading + 32'h20000000 >> 30);
          cz <= 33'(signed'(heading - {2'(heading + 32'h20000000 >> 30), 30'd0}));
          cx <= ddo_pkg::CordicOneQ30;
          cy <= '0;
          cnt <= '0;
          state <= S_COR_RUN;
        end
        S_COR_RUN: begin
          if (!cz[32]) begin
            cx <= cx - cy_sh;
            cy <= cy + cx_sh;
            cz <= cz - 33'(ddo_pkg::atan_turn(cstep));
          end else begin
            cx <= cx + cy_sh;
            cy <= cy - cx_sh;
            cz <= cz + 33'(ddo_pkg::atan_turn(cstep));
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(ddo_pkg::CordicSteps - 1)) state <= S_QUAD;
        end
        S_QUAD: begin
          case (quad)
            2'd0: begin trig_c <= cx; trig_s <= cy; end
            2'd1: begin trig_c <= -cy; trig_s <= cx; end
            2'd2: begin trig_c <= -cx; trig_s <= -cy; end
            default: begin trig_c <= cy; trig_s <= -cx; end
          endcase
          state <= S_RATE_X;
        end
        S_RATE_X: begin
          rate_x <= rate_sat;
          state <= S_RATE_Y;
        end
        S_RATE_Y: begin
          rate_y <= rate_sat;
          state <= S_POS_X;
        end
        S_POS_X: begin
          pos_x <= pnew;
          state <= S_POS_Y;
        end
        S_POS_Y: begin
          pos_y <= pnew;
          pos_x_out <= pos_x;
          pos_y_out <= pnew;
          heading_out <= heading;
          rate_x_out <= rate_x;
          rate_y_out <= rate_y;
          sequence_out <= tick_sequence;
          tick_sequence <= tick_sequence + 32'd1;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DDO_ASSERT_IMP(a_out_only_in_out, out_valid, state == S_OUT)
  `DDO_ASSERT_NEXT(a_seq_step, out_valid && out_ready, tick_sequence == sequence_out + 32'd1)
  `DDO_ASSERT_IMP(a_ready_excl, in_ready, !out_valid)
  `DDO_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(pos_x_out))
endmodule
`default_nettype wire

### bench/odometry_checker.sv
// ----------------------------------------------------------------------------
// odometry_checker
// Watches the request, spacing and result channels of the odometry block.
// It predicts each tick's pose from its own copy of the state and compares
// the results field by field, in order.
// ----------------------------------------------------------------------------
module odometry_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [0:0]         req_type,
  input  logic signed [31:0] left_vel_x,
  input  logic signed [31:0] left_vel_y,
  input  logic signed [31:0] right_vel_x,
  input  logic signed [31:0] right_vel_y,
  input  logic [23:0]        elapsed_time,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [47:0]        pos_x_out,
  input  logic [47:0]        pos_y_out,
  input  logic [31:0]        heading_out,
  input  logic [31:0]        rate_x_out,
  input  logic [31:0]        rate_y_out,
  input  logic [31:0]        sequence_out,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TurnLimit = 64'sd549755813887;
  localparam longint PosLimit = 64'sd140737488355327;

  typedef struct {
    logic [47:0] px;
    logic [47:0] py;
    logic [31:0] hd;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] sq;
  } pose_t;

  // Arctangents of 2^-i as fractions of a turn (2^32 per turn).
  longint atan_tab [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  pose_t       pose_q [$];
  logic [31:0] spacing;
  logic [31:0] fwd_speed;
  logic [31:0] heading;
  logic [31:0] seq_no;
  longint      turn;
  longint      px;
  longint      py;

  initial fail_count = 0;
  initial pending = 0;

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] root64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] wheel_mag(logic signed [31:0] vx, logic signed [31:0] vy);
    logic [63:0] ax;
    logic [63:0] ay;
    ax = mag(longint'(vx));
    ay = mag(longint'(vy));
    return root64(ax * ax + ay * ay);
  endfunction

  // Reduce to the nearest quarter turn, rotate the residual, then restore.
  function automatic void rotate(input logic [31:0] a, output longint c, output longint s);
    logic [31:0] sum;
    logic [31:0] rem;
    logic [1:0]  q;
    longint      z;
    longint      x;
    longint      y;
    longint      nx;
    sum = a + 32'h2000_0000;
    q = sum[31:30];
    rem = a - {q, 30'd0};
    z = longint'($signed(rem));
    x = longint'(ddo_pkg::CordicOneQ30);
    y = 0;
    for (int i = 0; i < ddo_pkg::CordicSteps && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tab[i];
      end
      x = nx;
    end
    case (q)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint rate_of(longint trig);
    logic [63:0] m;
    m = (64'(fwd_speed) * mag(trig)) >> 30;
    if (trig < 0) return m > 64'd2147483648 ? -64'sd2147483648 : -longint'(m);
    return m > 64'd2147483647 ? 64'sd2147483647 : longint'(m);
  endfunction

  function automatic longint move(longint p, longint rate, logic [23:0] dt);
    logic [63:0] m;
    longint      d;
    longint      r;
    m = (mag(rate) * 64'(dt)) >> 16;
    d = rate < 0 ? -longint'(m) : longint'(m);
    r = p + d;
    if (r > PosLimit) r = PosLimit;
    if (r < -PosLimit - 1) r = -PosLimit - 1;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    logic [31:0] l;
    logic [31:0] r;
    logic [63:0] dm;
    logic [63:0] q;
    logic [63:0] p;
    logic [31:0] dang;
    longint      c;
    longint      s;
    longint      rx;
    longint      ry;
    pose_t       want;
    if (rst) begin
      spacing = ddo_pkg::SpacingReset;
      fwd_speed = 0;
      turn = 0;
      px = 0;
      py = 0;
      heading = 0;
      seq_no = ddo_pkg::SequenceReset;
    end else begin
      if (cfg_valid && cfg_ready) spacing = cfg_data;
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, sequence %h", $time, sequence_out);
        end else begin
          want = pose_q.pop_front();
          check_field("pos_x", 64'(want.px), 64'(pos_x_out));
          check_field("pos_y", 64'(want.py), 64'(pos_y_out));
          check_field("heading", 64'(want.hd), 64'(heading_out));
          check_field("rate_x", 64'(want.rx), 64'(rate_x_out));
          check_field("rate_y", 64'(want.ry), 64'(rate_y_out));
          check_field("sequence", 64'(want.sq), 64'(sequence_out));
        end
      end
      if (in_valid && in_ready) begin
        if (req_type == ddo_pkg::ReqWheel) begin
          l = wheel_mag(left_vel_x, left_vel_y);
          r = wheel_mag(right_vel_x, right_vel_y);
          dm = r >= l ? 64'(r - l) : 64'(l - r);
          fwd_speed = 32'((64'(l) + 64'(r)) >> 1);
          // Zero spacing saturates in the sign of the difference.
          if (dm == 0) q = 0;
          else if (spacing == 0) q = 64'(TurnLimit) + 1;
          else q = (dm << 16) / 64'(spacing);
          if (r >= l) turn = q > 64'(TurnLimit) ? TurnLimit : longint'(q);
          else turn = q > 64'(TurnLimit) ? -TurnLimit - 1 : -longint'(q);
        end else begin
          p = mag(turn) * 64'(elapsed_time);
          dang = 32'(64'(p[63:32]) * 64'(ddo_pkg::InvTwoPiQ32)
                     + ((64'(p[31:0]) * 64'(ddo_pkg::InvTwoPiQ32)) >> 32));
          if (turn < 0) dang = -dang;
          heading = heading + dang;
          rotate(heading, c, s);
          rx = rate_of(c);
          ry = rate_of(s);
          px = move(px, rx, elapsed_time);
          py = move(py, ry, elapsed_time);
          pose_q.push_back('{px[47:0], py[47:0], heading, rx[31:0], ry[31:0], seq_no});
          seq_no = seq_no + 1;
        end
      end
    end
    pending = pose_q.size();
  end
endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the odometry block: a drive to position saturation, directed
// wheel and tick requests, then random requests under several spacings with
// random stalls on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_200_000;
  localparam int SettleCycles = 160;
  localparam logic [31:0] VelMin = 32'h8000_0000;
  localparam logic [31:0] VelMax = 32'h7fff_ffff;
  localparam logic [23:0] DtMax = 24'hff_ffff;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [0:0]         req_type = ddo_pkg::ReqWheel;
  logic signed [31:0] left_vel_x = 0;
  logic signed [31:0] left_vel_y = 0;
  logic signed [31:0] right_vel_x = 0;
  logic signed [31:0] right_vel_y = 0;
  logic [23:0]        elapsed_time = 0;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [31:0]        cfg_data = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [47:0] pos_x_out;
  logic signed [47:0] pos_y_out;
  logic [31:0]        heading_out;
  logic signed [31:0] rate_x_out;
  logic signed [31:0] rate_y_out;
  logic [31:0]        sequence_out;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  bit                 calm = 0;

  always #2 clk = ~clk;

  diff_drive_odometry i_dut (.*);

  odometry_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_vel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 70) return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return VelMin;
        1: return VelMax;
        2: return 32'hffff_ffff;
        default: return 0;
      endcase
    end
    return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
  endfunction

  function automatic logic [23:0] rand_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 24'($urandom_range(0, 1 << 17));
    if (r < 80) return 24'($urandom);
    if (r < 90) return 0;
    return DtMax;
  endfunction

  task automatic send(logic [0:0] kind, logic [31:0] lx, logic [31:0] ly,
                      logic [31:0] rx, logic [31:0] ry, logic [23:0] dt);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    req_type = kind;
    left_vel_x = lx;
    left_vel_y = ly;
    right_vel_x = rx;
    right_vel_y = ry;
    elapsed_time = dt;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // The fields that a request does not use still carry random values.
  task automatic wheel(logic [31:0] lx, logic [31:0] ly, logic [31:0] rx, logic [31:0] ry);
    send(ddo_pkg::ReqWheel, lx, ly, rx, ry, 24'($urandom));
  endtask

  task automatic tick(logic [23:0] dt);
    send(ddo_pkg::ReqTick, $urandom, $urandom, $urandom, $urandom, dt);
  endtask

  // A wheel request gives no result, so wait out its latency as well.
  task automatic settle();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_spacing(logic [31:0] v);
    settle();
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_run(int n);
    logic [31:0] lx;
    logic [31:0] ly;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        lx = rand_vel();
        ly = rand_vel();
        // Mirrored velocities give equal speeds and no turn.
        if ($urandom_range(0, 9) == 0) wheel(lx, ly, -lx, ly);
        else wheel(lx, ly, rand_vel(), rand_vel());
      end else begin
        tick(rand_dt());
      end
    end
  endtask

  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_ready = 0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  initial begin
    logic [31:0] spacings [6];
    spacings = '{0, 1, 32'hffff_ffff, $urandom, $urandom_range(1, 1 << 18),
                 ddo_pkg::SpacingReset};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Turn about three eighths of a turn, then drive hard until x and y
    // saturate in opposite directions.
    wheel(0, 0, 154415, 0);
    tick(65536);
    wheel(VelMin, VelMin, VelMin, VelMin);
    repeat (380) tick(DtMax);

    wheel(0, 0, 0, 0);
    tick(0);
    tick(DtMax);
    wheel(3 << 16, -(4 << 16), -(3 << 16), 4 << 16);
    tick(1);
    wheel(VelMax, VelMin, 0, 0);
    tick(DtMax);
    wheel(0, 0, VelMax, VelMax);
    tick(DtMax);
    wheel(32'hffff_ffff, 1, 1, 32'hffff_ffff);
    tick(65536);

    for (int i = 0; i < 6; i++) begin
      write_spacing(spacings[i]);
      calm = (i == 2);
      if (spacings[i] <= 1) begin
        wheel(VelMin, 0, 0, 0);
        tick(DtMax);
        wheel(5, 0, 5, 0);
        tick(DtMax);
      end
      random_run(150);
    end
    calm = 0;

    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/ddo_pkg.sv
rtl/diff_drive_odometry.sv
bench/odometry_checker.sv
bench/tb.sv
